// ===== rtl/core/sip_pkg.sv =====
`timescale 1ns / 1ps

package sip_pkg;

    localparam int IN_BITS  = 16;
    localparam int OUT_BITS = 32;

    typedef struct packed {
        logic signed [IN_BITS-1:0] p1_x;
        logic signed [IN_BITS-1:0] p1_y;
        logic signed [IN_BITS-1:0] p2_x;
        logic signed [IN_BITS-1:0] p2_y;
        logic signed [IN_BITS-1:0] q1_x;
        logic signed [IN_BITS-1:0] q1_y;
        logic signed [IN_BITS-1:0] q2_x;
        logic signed [IN_BITS-1:0] q2_y;
    } t_seg_in;

    typedef struct packed {
        logic                       hit;
        logic signed [OUT_BITS-1:0] cross_x;
        logic signed [OUT_BITS-1:0] cross_y;
    } t_seg_out;

    // per-item control carried alongside the arithmetic
    typedef struct packed {
        logic                hit;
        logic                use_sh;
        logic                neg_x;
        logic                neg_y;
        logic [OUT_BITS-1:0] sh_x;
        logic [OUT_BITS-1:0] sh_y;
    } t_side;

endpackage

// ===== rtl/core/sip_geom.sv =====
`timescale 1ns / 1ps

module sip_geom #(
    parameter int C = 16,
    parameter int F = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  sip_pkg::t_seg_in       i_word,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic signed [2*C+2:0]  o_den,
    output logic signed [2*C+2:0]  o_t,
    output logic signed [C-1:0]    o_ax,
    output logic signed [C-1:0]    o_ay,
    output logic signed [C:0]      o_dpx,
    output logic signed [C:0]      o_dpy,
    output sip_pkg::t_side         o_side
);

    localparam int PW = 2 * C + 2;
    localparam int DW = 2 * C + 3;
    localparam int OB = sip_pkg::OUT_BITS;

    logic ld1, ld2, ld3;
    logic r_v1, r_v2, r_v3;

    logic signed [C-1:0] c_ax, c_ay, c_bx, c_by, c_cx, c_cy, c_dx, c_dy;
    logic eq_ac, eq_ad, eq_bc, eq_bd, n_bbox;
    sip_pkg::t_side n_side1;

    // stage 1: coordinate differences, endpoint and box tests
    logic signed [C-1:0] r1_ax, r1_ay;
    logic signed [C:0]   r1_dpx, r1_dpy, r1_dqx, r1_dqy, r1_cax, r1_cay;
    logic signed [C:0]   r1_dax, r1_day, r1_bcx, r1_bcy;
    logic                r1_bbox;
    sip_pkg::t_side      r1_side;

    // stage 2: products
    logic signed [PW-1:0] r2_m1, r2_m2, r2_m3, r2_m4, r2_m5, r2_m6, r2_m7, r2_m8;
    logic signed [PW-1:0] r2_m9, r2_m10;
    logic signed [C-1:0]  r2_ax, r2_ay;
    logic signed [C:0]    r2_dpx, r2_dpy;
    logic                 r2_bbox;
    sip_pkg::t_side       r2_side;

    // stage 3: orientations, denominator, decision
    logic signed [DW-1:0] n_o1, n_o2, n_t, n_o4, n_den;
    logic                 n_cross;
    sip_pkg::t_side       n_side3;
    logic signed [DW-1:0] r3_den, r3_t;
    logic signed [C-1:0]  r3_ax, r3_ay;
    logic signed [C:0]    r3_dpx, r3_dpy;
    sip_pkg::t_side       r3_side;

    assign ld3     = !r_v3 || i_ready;
    assign ld2     = !r_v2 || ld3;
    assign ld1     = !r_v1 || ld2;
    assign o_ready = ld1;

    // bits above C are dropped, narrower fields are zero padded
    assign c_ax = C'({{C{1'b0}}, i_word.p1_x});
    assign c_ay = C'({{C{1'b0}}, i_word.p1_y});
    assign c_bx = C'({{C{1'b0}}, i_word.p2_x});
    assign c_by = C'({{C{1'b0}}, i_word.p2_y});
    assign c_cx = C'({{C{1'b0}}, i_word.q1_x});
    assign c_cy = C'({{C{1'b0}}, i_word.q1_y});
    assign c_dx = C'({{C{1'b0}}, i_word.q2_x});
    assign c_dy = C'({{C{1'b0}}, i_word.q2_y});

    always_comb begin
        eq_ac = (c_ax == c_cx) && (c_ay == c_cy);
        eq_ad = (c_ax == c_dx) && (c_ay == c_dy);
        eq_bc = (c_bx == c_cx) && (c_by == c_cy);
        eq_bd = (c_bx == c_dx) && (c_by == c_dy);
        n_bbox = ((c_ax <= c_cx) || (c_ax <= c_dx) || (c_bx <= c_cx) || (c_bx <= c_dx)) &&
                 ((c_cx <= c_ax) || (c_cx <= c_bx) || (c_dx <= c_ax) || (c_dx <= c_bx)) &&
                 ((c_ay <= c_cy) || (c_ay <= c_dy) || (c_by <= c_cy) || (c_by <= c_dy)) &&
                 ((c_cy <= c_ay) || (c_cy <= c_by) || (c_dy <= c_ay) || (c_dy <= c_by));
        n_side1        = '0;
        n_side1.use_sh = eq_ac || eq_ad || eq_bc || eq_bd;
        if (eq_ac || eq_ad) begin
            n_side1.sh_x = OB'((C+OB)'(c_ax) <<< F);
            n_side1.sh_y = OB'((C+OB)'(c_ay) <<< F);
        end else begin
            n_side1.sh_x = OB'((C+OB)'(c_bx) <<< F);
            n_side1.sh_y = OB'((C+OB)'(c_by) <<< F);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ld1) r_v1 <= i_valid;
            if (ld2) r_v2 <= r_v1;
            if (ld3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r1_ax   <= c_ax;
            r1_ay   <= c_ay;
            r1_dpx  <= (C+1)'(c_bx) - (C+1)'(c_ax);
            r1_dpy  <= (C+1)'(c_by) - (C+1)'(c_ay);
            r1_dqx  <= (C+1)'(c_dx) - (C+1)'(c_cx);
            r1_dqy  <= (C+1)'(c_dy) - (C+1)'(c_cy);
            r1_cax  <= (C+1)'(c_cx) - (C+1)'(c_ax);
            r1_cay  <= (C+1)'(c_cy) - (C+1)'(c_ay);
            r1_dax  <= (C+1)'(c_dx) - (C+1)'(c_ax);
            r1_day  <= (C+1)'(c_dy) - (C+1)'(c_ay);
            r1_bcx  <= (C+1)'(c_bx) - (C+1)'(c_cx);
            r1_bcy  <= (C+1)'(c_by) - (C+1)'(c_cy);
            r1_bbox <= n_bbox;
            r1_side <= n_side1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r2_m1   <= PW'(r1_dpx) * PW'(r1_cay);
            r2_m2   <= PW'(r1_dpy) * PW'(r1_cax);
            r2_m3   <= PW'(r1_dpx) * PW'(r1_day);
            r2_m4   <= PW'(r1_dpy) * PW'(r1_dax);
            r2_m5   <= PW'(r1_dqy) * PW'(r1_cax);
            r2_m6   <= PW'(r1_dqx) * PW'(r1_cay);
            r2_m7   <= PW'(r1_dqx) * PW'(r1_bcy);
            r2_m8   <= PW'(r1_dqy) * PW'(r1_bcx);
            r2_m9   <= PW'(r1_dpx) * PW'(r1_dqy);
            r2_m10  <= PW'(r1_dpy) * PW'(r1_dqx);
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_dpx  <= r1_dpx;
            r2_dpy  <= r1_dpy;
            r2_bbox <= r1_bbox;
            r2_side <= r1_side;
        end
    end

    // n_t doubles as the orientation of p1 against q1q2
    always_comb begin
        n_o1  = DW'(r2_m1) - DW'(r2_m2);
        n_o2  = DW'(r2_m3) - DW'(r2_m4);
        n_t   = DW'(r2_m5) - DW'(r2_m6);
        n_o4  = DW'(r2_m7) - DW'(r2_m8);
        n_den = DW'(r2_m9) - DW'(r2_m10);
        n_cross = r2_bbox && (n_den != '0) &&
                  (n_o1 != '0) && (n_o2 != '0) && (n_o1[DW-1] != n_o2[DW-1]) &&
                  (n_t != '0) && (n_o4 != '0) && (n_t[DW-1] != n_o4[DW-1]);
        n_side3     = r2_side;
        n_side3.hit = r2_side.use_sh || n_cross;
    end

    always_ff @(posedge i_clk) begin
        if (ld3) begin
            r3_den  <= n_den;
            r3_t    <= n_t;
            r3_ax   <= r2_ax;
            r3_ay   <= r2_ay;
            r3_dpx  <= r2_dpx;
            r3_dpy  <= r2_dpy;
            r3_side <= n_side3;
        end
    end

    assign o_valid = r_v3;
    assign o_den   = r3_den;
    assign o_t     = r3_t;
    assign o_ax    = r3_ax;
    assign o_ay    = r3_ay;
    assign o_dpx   = r3_dpx;
    assign o_dpy   = r3_dpy;
    assign o_side  = r3_side;

endmodule

// ===== rtl/core/sip_num.sv =====
`timescale 1ns / 1ps

module sip_num #(
    parameter int C = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [2*C+2:0]  i_den,
    input  logic signed [2*C+2:0]  i_t,
    input  logic signed [C-1:0]    i_ax,
    input  logic signed [C-1:0]    i_ay,
    input  logic signed [C:0]      i_dpx,
    input  logic signed [C:0]      i_dpy,
    input  sip_pkg::t_side         i_side,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [3*C+4:0]         o_nx,
    output logic [3*C+4:0]         o_ny,
    output logic [2*C+2:0]         o_d,
    output sip_pkg::t_side         o_side
);

    localparam int DW  = 2 * C + 3;
    localparam int LW  = (DW + 1) / 2;
    localparam int HW  = DW - LW;
    localparam int PPW = C + LW + 2;
    localparam int NB  = 3 * C + 5;

    logic ld1, ld2;
    logic r_v1, r_v2;

    logic signed [HW-1:0] den_hi, t_hi;
    logic signed [LW:0]   den_lo, t_lo;

    // stage 1: multiplies split at bit LW of the wide operand
    logic signed [PPW-1:0] r1_xa_hi, r1_xa_lo, r1_xb_hi, r1_xb_lo;
    logic signed [PPW-1:0] r1_ya_hi, r1_ya_lo, r1_yb_hi, r1_yb_lo;
    logic signed [DW-1:0]  r1_den;
    sip_pkg::t_side        r1_side;

    // stage 2: sums and magnitudes
    logic signed [NB-1:0] n_num_x, n_num_y;
    sip_pkg::t_side       n_side;
    logic [NB-1:0]        r2_nx, r2_ny;
    logic [DW-1:0]        r2_d;
    sip_pkg::t_side       r2_side;

    assign ld2     = !r_v2 || i_ready;
    assign ld1     = !r_v1 || ld2;
    assign o_ready = ld1;

    assign den_hi = i_den[DW-1:LW];
    assign t_hi   = i_t[DW-1:LW];
    assign den_lo = {1'b0, i_den[LW-1:0]};
    assign t_lo   = {1'b0, i_t[LW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (ld1) r_v1 <= i_valid;
            if (ld2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r1_xa_hi <= PPW'(i_ax) * PPW'(den_hi);
            r1_xa_lo <= PPW'(i_ax) * PPW'(den_lo);
            r1_xb_hi <= PPW'(i_dpx) * PPW'(t_hi);
            r1_xb_lo <= PPW'(i_dpx) * PPW'(t_lo);
            r1_ya_hi <= PPW'(i_ay) * PPW'(den_hi);
            r1_ya_lo <= PPW'(i_ay) * PPW'(den_lo);
            r1_yb_hi <= PPW'(i_dpy) * PPW'(t_hi);
            r1_yb_lo <= PPW'(i_dpy) * PPW'(t_lo);
            r1_den   <= i_den;
            r1_side  <= i_side;
        end
    end

    always_comb begin
        n_num_x = (NB'(r1_xa_hi) <<< LW) + NB'(r1_xa_lo) + (NB'(r1_xb_hi) <<< LW) +
                  NB'(r1_xb_lo);
        n_num_y = (NB'(r1_ya_hi) <<< LW) + NB'(r1_ya_lo) + (NB'(r1_yb_hi) <<< LW) +
                  NB'(r1_yb_lo);
        n_side       = r1_side;
        n_side.neg_x = n_num_x[NB-1] ^ r1_den[DW-1];
        n_side.neg_y = n_num_y[NB-1] ^ r1_den[DW-1];
    end

    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r2_nx   <= n_num_x[NB-1] ? NB'(-n_num_x) : NB'(n_num_x);
            r2_ny   <= n_num_y[NB-1] ? NB'(-n_num_y) : NB'(n_num_y);
            r2_d    <= r1_den[DW-1] ? DW'(-r1_den) : DW'(r1_den);
            r2_side <= n_side;
        end
    end

    assign o_valid = r_v2;
    assign o_nx    = r2_nx;
    assign o_ny    = r2_ny;
    assign o_d     = r2_d;
    assign o_side  = r2_side;

endmodule

// ===== rtl/core/sip_div.sv =====
`timescale 1ns / 1ps

module sip_div #(
    parameter int NB = 53,
    parameter int DW = 35,
    parameter int QB = 32,
    parameter int F  = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [NB-1:0]   i_nx,
    input  logic [NB-1:0]   i_ny,
    input  logic [DW-1:0]   i_d,
    input  sip_pkg::t_side  i_side,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [QB-1:0]   o_qx,
    output logic [QB-1:0]   o_qy,
    output sip_pkg::t_side  o_side
);

    localparam int RB = NB + F;

    // one quotient bit per stage, most significant first
    logic [RB-1:0]  r_rx [QB];
    logic [RB-1:0]  r_ry [QB];
    logic [QB-1:0]  r_qx [QB];
    logic [QB-1:0]  r_qy [QB];
    logic [DW-1:0]  r_d  [QB];
    sip_pkg::t_side r_s  [QB];
    logic [QB-1:0]  r_v;
    logic [QB-1:0]  ld;

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [RB-1:0]  a_rx, a_ry, sub, n_rx, n_ry;
        logic [QB-1:0]  a_qx, a_qy, n_qx, n_qy;
        logic [DW-1:0]  a_d;
        sip_pkg::t_side a_s;
        logic           a_v;
        logic [RB:0]    dif_x, dif_y;

        if (k == 0) begin : g_head
            assign a_rx = RB'(i_nx) << F;
            assign a_ry = RB'(i_ny) << F;
            assign a_qx = '0;
            assign a_qy = '0;
            assign a_d  = i_d;
            assign a_s  = i_side;
            assign a_v  = i_valid;
        end else begin : g_body
            assign a_rx = r_rx[k-1];
            assign a_ry = r_ry[k-1];
            assign a_qx = r_qx[k-1];
            assign a_qy = r_qy[k-1];
            assign a_d  = r_d[k-1];
            assign a_s  = r_s[k-1];
            assign a_v  = r_v[k-1];
        end

        if (k == QB - 1) begin : g_last
            assign ld[k] = !r_v[k] || i_ready;
        end else begin : g_mid
            assign ld[k] = !r_v[k] || ld[k+1];
        end

        always_comb begin
            sub   = RB'(a_d) << (QB - 1 - k);
            dif_x = {1'b0, a_rx} - {1'b0, sub};
            dif_y = {1'b0, a_ry} - {1'b0, sub};
            n_rx  = dif_x[RB] ? a_rx : dif_x[RB-1:0];
            n_ry  = dif_y[RB] ? a_ry : dif_y[RB-1:0];
            n_qx  = a_qx;
            n_qy  = a_qy;
            n_qx[QB-1-k] = !dif_x[RB];
            n_qy[QB-1-k] = !dif_y[RB];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (ld[k]) begin
                r_v[k] <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (ld[k]) begin
                r_rx[k] <= n_rx;
                r_ry[k] <= n_ry;
                r_qx[k] <= n_qx;
                r_qy[k] <= n_qy;
                r_d[k]  <= a_d;
                r_s[k]  <= a_s;
            end
        end
    end

    assign o_ready = ld[0];
    assign o_valid = r_v[QB-1];
    assign o_qx    = r_qx[QB-1];
    assign o_qy    = r_qy[QB-1];
    assign o_side  = r_s[QB-1];

endmodule

// ===== rtl/core/segment_intersection_point.sv =====
`timescale 1ns / 1ps

// Segment intersection: one segment pair per cycle in while the output is not stalled,
// one result word per pair out, in order. The pipeline has three geometry stages
// (differences, cross products, orientation tests), two stages that form the scaled
// numerators, one restoring-divider stage per quotient bit for x and y in parallel,
// and the output register. The divider chain sets the latency; throughput is one pair
// per clock and a stalled output only holds the pipeline once every stage is full.
module segment_intersection_point #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sip_pkg::t_seg_in    i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output sip_pkg::t_seg_out   o_word
);

    localparam int C  = COORD_BITS;
    localparam int DW = 2 * C + 3;
    localparam int NB = 3 * C + 5;
    localparam int QB = C + FRAC_BITS;
    localparam int OB = sip_pkg::OUT_BITS;

    logic                 g_valid, g_ready;
    logic signed [DW-1:0] g_den, g_t;
    logic signed [C-1:0]  g_ax, g_ay;
    logic signed [C:0]    g_dpx, g_dpy;
    sip_pkg::t_side       g_side;

    logic                 m_valid, m_ready;
    logic [NB-1:0]        m_nx, m_ny;
    logic [DW-1:0]        m_d;
    sip_pkg::t_side       m_side;

    logic                 q_valid, q_ready;
    logic [QB-1:0]        q_x, q_y;
    sip_pkg::t_side       q_side;

    logic [OB-1:0]        v_x, v_y;
    sip_pkg::t_seg_out    n_word;
    logic                 r_ov;
    sip_pkg::t_seg_out    r_word;

    sip_geom #(.C(C), .F(FRAC_BITS)) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_word  (i_word),
        .o_valid (g_valid),
        .i_ready (g_ready),
        .o_den   (g_den),
        .o_t     (g_t),
        .o_ax    (g_ax),
        .o_ay    (g_ay),
        .o_dpx   (g_dpx),
        .o_dpy   (g_dpy),
        .o_side  (g_side)
    );

    sip_num #(.C(C)) u_num (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (g_valid),
        .o_ready (g_ready),
        .i_den   (g_den),
        .i_t     (g_t),
        .i_ax    (g_ax),
        .i_ay    (g_ay),
        .i_dpx   (g_dpx),
        .i_dpy   (g_dpy),
        .i_side  (g_side),
        .o_valid (m_valid),
        .i_ready (m_ready),
        .o_nx    (m_nx),
        .o_ny    (m_ny),
        .o_d     (m_d),
        .o_side  (m_side)
    );

    sip_div #(.NB(NB), .DW(DW), .QB(QB), .F(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m_valid),
        .o_ready (m_ready),
        .i_nx    (m_nx),
        .i_ny    (m_ny),
        .i_d     (m_d),
        .i_side  (m_side),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_qx    (q_x),
        .o_qy    (q_y),
        .o_side  (q_side)
    );

    assign q_ready = !r_ov || i_ready;

    // quotient magnitude to signed word, shared endpoints take their stored point, misses give zero
    always_comb begin
        v_x = OB'({{OB{1'b0}}, q_x});
        v_y = OB'({{OB{1'b0}}, q_y});
        n_word = '0;
        if (q_side.hit) begin
            n_word.hit = 1'b1;
            if (q_side.use_sh) begin
                n_word.cross_x = q_side.sh_x;
                n_word.cross_y = q_side.sh_y;
            end else begin
                n_word.cross_x = q_side.neg_x ? -v_x : v_x;
                n_word.cross_y = q_side.neg_y ? -v_y : v_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (q_ready) begin
            r_ov <= q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_ready) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_ov;
    assign o_word  = r_word;

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_word.hit |-> o_word.cross_x == '0 && o_word.cross_y == '0)
        else $error("miss word carries a nonzero point");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with an empty output register");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid right after reset");

endmodule
